@@ design/fir_df_pkg.sv @@
// shared types and constants of the direct-form fir filter
package fir_df_pkg;

   localparam int TAPS_W       = 5;
   localparam int COEF_INDEX_W = 4;

   localparam logic [TAPS_W-1:0] TAPS_RESET = 5'd16;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_COEF   = 1'b1
   } kind_type;

   // control broadcast from the top level to every tap cell
   typedef struct packed {
      logic                    advance;
      logic                    shift;
      logic                    clear;
      logic                    coef_we;
      logic [COEF_INDEX_W-1:0] coef_index;
      logic [TAPS_W-1:0]       taps;
   } cell_ctl_type;

endpackage

@@ design/fir_df_cell.sv @@
// one tap cell: delay register, coefficient register, multiply and accumulate stage
module fir_df_cell #(
   parameter int CELL_INDEX   = 0,
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACC_WIDTH    = 36
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fir_df_pkg::cell_ctl_type       ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_prev,
   input  logic signed [SAMPLE_WIDTH-1:0] coef_value,
   input  logic                           token_prev,
   input  logic signed [ACC_WIDTH-1:0]    acc_prev,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out,
   output logic                           token_out,
   output logic signed [ACC_WIDTH-1:0]    acc_out
);
   import fir_df_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_WIDTH;
   localparam logic signed [ACC_WIDTH:0] ACC_MAX =
      $signed({2'b00, {(ACC_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_WIDTH:0] ACC_MIN =
      $signed({2'b11, {(ACC_WIDTH-2){1'b0}}, 1'b1});
   localparam logic TAPS_REACH = CELL_INDEX < (1 << TAPS_W);
   localparam logic COEF_REACH = CELL_INDEX < (1 << COEF_INDEX_W);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_WIDTH-1:0] coef_ff, coef_in;
   logic                           token_ff, token_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;

   logic                           tap_on;
   logic                           coef_sel;
   logic signed [PROD_W-1:0]       product;
   logic signed [ACC_WIDTH:0]      sum;
   logic signed [ACC_WIDTH-1:0]    sum_sat;

   always_comb begin
      // a tap count of zero still uses the first tap
      tap_on = (CELL_INDEX == 0) ||
               (TAPS_REACH && (TAPS_W'(CELL_INDEX) < ctl.taps));
      coef_sel = ctl.coef_we && COEF_REACH &&
                 (ctl.coef_index == COEF_INDEX_W'(CELL_INDEX));
   end

   always_comb begin
      product = sample_ff * coef_ff;
      sum = $signed({acc_prev[ACC_WIDTH-1], acc_prev}) +
            $signed({{(ACC_WIDTH+1-PROD_W){product[PROD_W-1]}}, product});
      // clamp at the accumulator limits
      if (sum > ACC_MAX) begin
         sum_sat = ACC_MAX[ACC_WIDTH-1:0];
      end else if (sum < ACC_MIN) begin
         sum_sat = ACC_MIN[ACC_WIDTH-1:0];
      end else begin
         sum_sat = sum[ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      if (ctl.clear) begin
         sample_in = '0;
      end else if (ctl.shift) begin
         sample_in = sample_prev;
      end else begin
         sample_in = sample_ff;
      end
      coef_in  = coef_sel ? coef_value : coef_ff;
      token_in = ctl.advance ? token_prev : token_ff;
      if (!ctl.advance) begin
         acc_in = acc_ff;
      end else if (tap_on) begin
         acc_in = sum_sat;
      end else begin
         acc_in = acc_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
         token_ff  <= 1'b0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
         token_ff  <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sample_out = sample_ff;
   assign token_out  = token_ff;
   assign acc_out    = acc_ff;

endmodule

@@ design/fir_df_round.sv @@
// rounding half up and saturation of the accumulated sum to sample width
module fir_df_round #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACC_WIDTH    = 36
) (
   input  logic signed [ACC_WIDTH-1:0]    acc,
   output logic signed [SAMPLE_WIDTH-1:0] filtered,
   output logic                           saturated
);
   import fir_df_pkg::*;

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int Q_W  = ACC_WIDTH - FRAC;
   localparam logic signed [ACC_WIDTH:0] HALF =
      $signed({{(ACC_WIDTH+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
   localparam logic signed [ACC_WIDTH:0] ACC_MAX =
      $signed({2'b00, {(ACC_WIDTH-1){1'b1}}});
   localparam logic signed [Q_W-1:0] VAL_MAX =
      $signed({{(Q_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [Q_W-1:0] VAL_MIN =
      $signed({{(Q_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

   logic signed [ACC_WIDTH:0]   sum;
   logic signed [ACC_WIDTH-1:0] rounded;
   logic signed [Q_W-1:0]       q;

   always_comb begin
      sum = $signed({acc[ACC_WIDTH-1], acc}) + HALF;
      rounded = (sum > ACC_MAX) ? ACC_MAX[ACC_WIDTH-1:0] : sum[ACC_WIDTH-1:0];
      // dropping the fraction bits of a two's complement value is a floor
      q = $signed(rounded[ACC_WIDTH-1:FRAC]);
      if (q > VAL_MAX) begin
         filtered  = VAL_MAX[SAMPLE_WIDTH-1:0];
         saturated = 1'b1;
      end else if (q < VAL_MIN) begin
         filtered  = VAL_MIN[SAMPLE_WIDTH-1:0];
         saturated = 1'b1;
      end else begin
         filtered  = q[SAMPLE_WIDTH-1:0];
         saturated = 1'b0;
      end
   end

endmodule

@@ design/fir_filter_direct_form_core.sv @@
// Direct-form FIR filter built as a chain of NUM_TAPS tap cells. After a sample transfer
// no further item is taken until its result has passed the head register, each tap cell
// in turn as the partial sum moves down the chain, and rounding into the output register;
// a stalled output register holds the chain. A coefficient write gives no result and does
// not stall the input side. Coefficient 0 weights the newest sample. Writing the tap
// count clears the delay line and keeps the coefficients; a tap count of 0 acts as 1 and
// one above NUM_TAPS acts as NUM_TAPS. Results are rounded half up to Q1.(SAMPLE_WIDTH-1)
// and clipped, with rsp_saturated set on clipping.
module fir_filter_direct_form_core #(
   parameter int NUM_TAPS     = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample,
   input  logic [fir_df_pkg::COEF_INDEX_W-1:0]     req_coef_index,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_coef_value,
   input  logic                                    req_end_of_block,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_filtered,
   output logic                                    rsp_saturated,
   output logic                                    rsp_last_of_block,
   input  logic                                    csr_write_enable,
   input  logic [fir_df_pkg::TAPS_W-1:0]           csr_write_data
);
   import fir_df_pkg::*;

   localparam int SUM_W     = 2 * SAMPLE_WIDTH + $clog2(NUM_TAPS);
   localparam int ACC_WIDTH = (SUM_W > 64) ? 64 : SUM_W;

   logic [TAPS_W-1:0]              taps_ff, taps_in;
   logic                           busy_ff, busy_in;
   logic                           start_ff, start_in;
   logic                           last_ff, last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                           rsp_saturated_ff, rsp_saturated_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           take_sample;
   logic                           take_coef;
   logic                           result_ready;
   logic                           rsp_load;
   cell_ctl_type                   ctl;

   logic signed [SAMPLE_WIDTH-1:0] sample_q [NUM_TAPS];
   logic                           token_q  [NUM_TAPS];
   logic signed [ACC_WIDTH-1:0]    acc_q    [NUM_TAPS];

   logic signed [SAMPLE_WIDTH-1:0] round_filtered;
   logic                           round_saturated;

   always_comb begin
      accept       = req_valid && !req_stall;
      take_sample  = accept && (kind_type'(req_kind) == KIND_SAMPLE);
      take_coef    = accept && (kind_type'(req_kind) == KIND_COEF);
      result_ready = token_q[NUM_TAPS-1];
      rsp_load     = result_ready && (!rsp_valid_ff || !rsp_stall);

      ctl.advance    = !result_ready || rsp_load;
      ctl.shift      = take_sample;
      ctl.clear      = csr_write_enable;
      ctl.coef_we    = take_coef;
      ctl.coef_index = req_coef_index;
      ctl.taps       = taps_ff;
   end

   genvar k;
   generate
      for (k = 0; k < NUM_TAPS; k++) begin : g_tap
         logic signed [SAMPLE_WIDTH-1:0] sample_prev;
         logic                           token_prev;
         logic signed [ACC_WIDTH-1:0]    acc_prev;

         if (k == 0) begin : g_head
            assign sample_prev = req_sample;
            assign token_prev  = start_ff;
            assign acc_prev    = '0;
         end else begin : g_body
            assign sample_prev = sample_q[k-1];
            assign token_prev  = token_q[k-1];
            assign acc_prev    = acc_q[k-1];
         end

         fir_df_cell #(
            .CELL_INDEX   (k),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACC_WIDTH    (ACC_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .sample_prev (sample_prev),
            .coef_value  (req_coef_value),
            .token_prev  (token_prev),
            .acc_prev    (acc_prev),
            .sample_out  (sample_q[k]),
            .token_out   (token_q[k]),
            .acc_out     (acc_q[k])
         );
      end
   endgenerate

   fir_df_round #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_round (
      .acc       (acc_q[NUM_TAPS-1]),
      .filtered  (round_filtered),
      .saturated (round_saturated)
   );

   always_comb begin
      taps_in  = csr_write_enable ? csr_write_data : taps_ff;
      start_in = take_sample;
      last_in  = take_sample ? req_end_of_block : last_ff;
      // busy from a sample transfer until its result reaches the output register
      if (take_sample) begin
         busy_in = 1'b1;
      end else if (rsp_load) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      rsp_valid_in     = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_filtered_in  = rsp_load ? round_filtered : rsp_filtered_ff;
      rsp_saturated_in = rsp_load ? round_saturated : rsp_saturated_ff;
      rsp_last_in      = rsp_load ? last_ff : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff      <= TAPS_RESET;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         taps_ff      <= taps_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff          <= last_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_saturated_ff <= rsp_saturated_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall         = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_saturated     = rsp_saturated_ff;
   assign rsp_last_of_block = rsp_last_ff;

endmodule

@@ design/fir_df_checker.sv @@
// port-level checks of the direct-form fir filter, bound to the top level
module fir_df_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0]      rsp_filtered,
   input logic                                rsp_saturated,
   input logic                                rsp_last_of_block
);
   import fir_df_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] VAL_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] VAL_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered) &&
         $stable(rsp_saturated) && $stable(rsp_last_of_block))
      else $error("stalled result changed");

   // a clipped result sits at one of the range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_filtered == VAL_MAX) || (rsp_filtered == VAL_MIN))
      else $error("saturated result not at a range limit");

   // a sample keeps the input side stalled while it works through the chain
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (kind_type'(req_kind) == KIND_SAMPLE) |=> req_stall)
      else $error("input taken while a sample is in flight");

   // no result can appear the cycle after any transfer into the block
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind fir_filter_direct_form_core fir_df_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fir_df_checker (.*);
